// File: hdl/timed_register_write_replay_defines.svh
// assertion macros for the timed register write replay block
`ifndef TIMED_REGISTER_WRITE_REPLAY_DEFINES_SVH
`define TIMED_REGISTER_WRITE_REPLAY_DEFINES_SVH
`ifndef ASSERT_OFF
`define TRWR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TRWR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRWR_ASSERT(lbl, clk, rstn, prop, msg)
`define TRWR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/trwr_pkg.sv
// shared types and codes of the timed register write replay block
`timescale 1ns / 1ps
package trwr_pkg;

    localparam int CUR_W = 13;

    typedef enum logic [3:0] {
        REQ_CLEAR  = 4'd0,
        REQ_HEADER = 4'd1,
        REQ_VALUE  = 4'd2,
        REQ_START  = 4'd3,
        REQ_STOP   = 4'd4,
        REQ_PAUSE  = 4'd5,
        REQ_RESUME = 4'd6,
        REQ_TICK   = 4'd7,
        REQ_STATUS = 4'd8
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_LOADED  = 2'd1,
        MODE_PLAYING = 2'd2,
        MODE_PAUSED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_FULL    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ENT   = 4'b0010,
        ST_VAL   = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_seq_state;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

endpackage

// File: hdl/trwr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module trwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/timed_register_write_replay.sv
// top level of the timed register write replay block
//
// channel  dir  tuser              tlast    tdata
// s        in   req_type           -        entry_time, first_addr, value_count, word_value
// m        out  result_kind        run_end  write_addr .. status_code
//
// every request but a tick gives one status report
// while playing, a tick steps through the entries that are due and sends their writes,
// at most MAX_WRITES_PER_TICK writes per tick
// the tables are not cleared: clear only resets counts, so reset is immediate
// a stalled master side holds the sequencer; input waits until the tick ends
`timescale 1ns / 1ps
`include "timed_register_write_replay_defines.svh"
module timed_register_write_replay #(
    parameter int MAX_ENTRIES         = 256,
    parameter int VALUE_WORDS         = 4096,
    parameter int MAX_WRITES_PER_TICK = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // entry_time[31:0], first_addr[47:32], value_count[60:48], word_value[76:61]
    input  logic [79:0] i_s_tdata,
    // req_type[3:0]
    input  logic [3:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // write_addr[15:0], write_data[31:16], play_state[33:32], position[42:34],
    // entry_total[51:43], elapsed_now[83:52], status_code[85:84]
    output logic [87:0] o_m_tdata,
    // result_kind[0]
    output logic        o_m_tuser,
    output logic        o_m_tlast
);
    // widths that follow from the table sizes
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int VW  = $clog2(VALUE_WORDS + 1);
    localparam int VAW = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;
    localparam int NW  = $clog2(MAX_WRITES_PER_TICK + 1);
    localparam int ENT_W = 32 + 16 + VW + VW;
    localparam int CW  = trwr_pkg::CUR_W;

    // input word fields
    logic [3:0]  s_req;
    logic [31:0] s_time;
    logic [15:0] s_addr;
    logic [12:0] s_count;
    logic [15:0] s_value;
    assign s_req   = i_s_tuser;
    assign s_time  = i_s_tdata[31:0];
    assign s_addr  = i_s_tdata[47:32];
    assign s_count = i_s_tdata[60:48];
    assign s_value = i_s_tdata[76:61];

    // control state
    trwr_pkg::t_mode      r_mode, n_mode;
    trwr_pkg::t_seq_state r_state, n_state;
    logic [EW-1:0]  r_count, n_count;
    logic [VW-1:0]  r_fill, n_fill;
    logic [EW-1:0]  r_next, n_next;
    logic [CW-1:0]  r_cursor, n_cursor;
    logic [31:0]    r_elapsed, n_elapsed;
    logic [NW-1:0]  r_nwr, n_nwr;
    logic           r_pend_v, n_pend_v;
    logic           r_out_v;

    // last loaded entry, kept so a value rewrites its entry without a read
    logic [31:0]   r_last_time, n_last_time;
    logic [15:0]   r_last_addr, n_last_addr;
    logic [VW-1:0] r_last_off, n_last_off;
    logic [VW-1:0] r_last_len, n_last_len;

    // entry under playback
    logic [15:0]   r_e_addr, n_e_addr;
    logic [VW-1:0] r_e_off, n_e_off;
    logic [VW-1:0] r_e_len, n_e_len;

    // write held back until it is known whether it ends the run
    logic [15:0] r_pend_addr, n_pend_addr;
    logic [15:0] r_pend_data, n_pend_data;

    // output register
    logic        r_out_kind, r_out_last;
    logic [15:0] r_out_addr, r_out_data;
    logic [1:0]  r_out_state, r_out_sts;
    logic [8:0]  r_out_pos, r_out_total;
    logic [31:0] r_out_elapsed;

    logic        out_load;
    logic        out_kind, out_last;
    logic [15:0] out_addr, out_data;
    logic [1:0]  out_sts;
    logic        out_report;

    // memory ports
    logic             ent_we;
    logic [IW-1:0]    ent_wa;
    logic [ENT_W-1:0] ent_wd;
    logic [ENT_W-1:0] ent_rd;
    logic             val_we;
    logic [VAW-1:0]   val_wa;
    logic [15:0]      val_wd;
    logic [15:0]      val_rd;
    logic [VAW-1:0]   val_ra;

    logic out_free;
    logic in_fire;
    logic [31:0] rd_time;
    logic [15:0] rd_addr;
    logic [VW-1:0] rd_off, rd_len;

    assign out_free   = !r_out_v || i_m_tready;
    assign o_s_tready = (r_state == trwr_pkg::ST_IDLE) && out_free;
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign rd_time = ent_rd[ENT_W-1 -: 32];
    assign rd_addr = ent_rd[2*VW +: 16];
    assign rd_off  = ent_rd[VW +: VW];
    assign rd_len  = ent_rd[VW-1:0];

    trwr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_wa),
        .i_wdata (ent_wd),
        .i_raddr (n_next[IW-1:0]),
        .o_rdata (ent_rd)
    );

    // value read address follows the next cursor so the registered read data lines up with the cursor register
    assign val_ra = VAW'(n_e_off) + VAW'(n_cursor);

    trwr_ram #(.WIDTH(16), .DEPTH(VALUE_WORDS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_wa),
        .i_wdata (val_wd),
        .i_raddr (val_ra),
        .o_rdata (val_rd)
    );

    always_comb begin
        n_mode      = r_mode;
        n_state     = r_state;
        n_count     = r_count;
        n_fill      = r_fill;
        n_next      = r_next;
        n_cursor    = r_cursor;
        n_elapsed   = r_elapsed;
        n_nwr       = r_nwr;
        n_pend_v    = r_pend_v;
        n_pend_addr = r_pend_addr;
        n_pend_data = r_pend_data;
        n_last_time = r_last_time;
        n_last_addr = r_last_addr;
        n_last_off  = r_last_off;
        n_last_len  = r_last_len;
        n_e_addr    = r_e_addr;
        n_e_off     = r_e_off;
        n_e_len     = r_e_len;
        out_load    = 1'b0;
        out_report  = 1'b0;
        out_kind    = trwr_pkg::KIND_WRITE;
        out_last    = 1'b0;
        out_addr    = r_pend_addr;
        out_data    = r_pend_data;
        out_sts     = trwr_pkg::STS_OK;
        ent_we      = 1'b0;
        ent_wa      = r_count[IW-1:0];
        ent_wd      = {s_time, s_addr, r_fill, VW'(0)};
        val_we      = 1'b0;
        val_wa      = r_fill[VAW-1:0];
        val_wd      = s_value;

        case (r_state)
            trwr_pkg::ST_IDLE: begin
                if (in_fire) begin
                    out_report = (s_req != trwr_pkg::REQ_TICK);
                    case (s_req)
                        trwr_pkg::REQ_CLEAR: begin
                            n_mode    = trwr_pkg::MODE_IDLE;
                            n_count   = '0;
                            n_fill    = '0;
                            n_next    = '0;
                            n_cursor  = '0;
                            n_elapsed = '0;
                        end
                        trwr_pkg::REQ_HEADER: begin
                            if (r_mode == trwr_pkg::MODE_PLAYING ||
                                r_mode == trwr_pkg::MODE_PAUSED) begin
                                out_sts = trwr_pkg::STS_INVALID;
                            end else if (r_count >= EW'(MAX_ENTRIES)) begin
                                out_sts = trwr_pkg::STS_FULL;
                            end else begin
                                ent_we      = 1'b1;
                                n_last_time = s_time;
                                n_last_addr = s_addr;
                                n_last_off  = r_fill;
                                n_last_len  = '0;
                                n_count     = r_count + EW'(1);
                                n_cursor    = s_count;
                                n_mode      = trwr_pkg::MODE_LOADED;
                            end
                        end
                        trwr_pkg::REQ_VALUE: begin
                            if (r_mode != trwr_pkg::MODE_LOADED || r_cursor == '0 ||
                                r_count == '0) begin
                                out_sts = trwr_pkg::STS_INVALID;
                            end else if (r_fill >= VW'(VALUE_WORDS)) begin
                                n_cursor = r_cursor - CW'(1);
                                out_sts  = trwr_pkg::STS_FULL;
                            end else begin
                                val_we     = 1'b1;
                                n_fill     = r_fill + VW'(1);
                                n_last_len = r_last_len + VW'(1);
                                ent_we     = 1'b1;
                                ent_wa     = IW'(r_count - EW'(1));
                                ent_wd     = {r_last_time, r_last_addr, r_last_off,
                                              n_last_len};
                                n_cursor   = r_cursor - CW'(1);
                            end
                        end
                        trwr_pkg::REQ_START: begin
                            if (r_mode == trwr_pkg::MODE_IDLE || r_count == '0) begin
                                out_sts = trwr_pkg::STS_INVALID;
                            end else begin
                                n_next    = '0;
                                n_cursor  = '0;
                                n_elapsed = '0;
                                n_mode    = trwr_pkg::MODE_PLAYING;
                            end
                        end
                        trwr_pkg::REQ_STOP: begin
                            n_mode    = (r_count == '0) ? trwr_pkg::MODE_IDLE
                                                        : trwr_pkg::MODE_LOADED;
                            n_next    = '0;
                            n_cursor  = '0;
                            n_elapsed = '0;
                        end
                        trwr_pkg::REQ_PAUSE: begin
                            if (r_mode == trwr_pkg::MODE_PLAYING) begin
                                n_mode = trwr_pkg::MODE_PAUSED;
                            end else begin
                                out_sts = trwr_pkg::STS_INVALID;
                            end
                        end
                        trwr_pkg::REQ_RESUME: begin
                            if (r_mode == trwr_pkg::MODE_PAUSED) begin
                                n_mode = trwr_pkg::MODE_PLAYING;
                            end else begin
                                out_sts = trwr_pkg::STS_INVALID;
                            end
                        end
                        trwr_pkg::REQ_TICK: begin
                            if (r_mode == trwr_pkg::MODE_PLAYING ||
                                r_mode == trwr_pkg::MODE_PAUSED) begin
                                if (r_elapsed != 32'hFFFF_FFFF) begin
                                    n_elapsed = r_elapsed + 32'd1;
                                end
                            end
                            if (r_mode == trwr_pkg::MODE_PLAYING) begin
                                if (r_next >= r_count) begin
                                    // run finished on an earlier tick
                                    n_mode    = trwr_pkg::MODE_LOADED;
                                    n_next    = '0;
                                    n_cursor  = '0;
                                    n_elapsed = '0;
                                end else begin
                                    n_nwr   = '0;
                                    n_state = trwr_pkg::ST_ENT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (out_report) begin
                        out_load = 1'b1;
                        out_kind = trwr_pkg::KIND_REPORT;
                        out_last = 1'b1;
                    end
                end
            end
            trwr_pkg::ST_ENT: begin
                n_e_addr = rd_addr;
                n_e_off  = rd_off;
                n_e_len  = rd_len;
                if (rd_time > r_elapsed) begin
                    n_state = trwr_pkg::ST_FLUSH;
                end else if (32'(r_cursor) < 32'(rd_len)) begin
                    n_state = trwr_pkg::ST_VAL;
                end else begin
                    n_next   = r_next + EW'(1);
                    n_cursor = '0;
                    if (n_next >= r_count) begin
                        n_state = trwr_pkg::ST_FLUSH;
                    end
                end
            end
            trwr_pkg::ST_VAL: begin
                if (!r_pend_v || out_free) begin
                    // older held write is not the last one: send it on
                    out_load    = r_pend_v;
                    n_pend_v    = 1'b1;
                    n_pend_addr = r_e_addr + 16'(r_cursor);
                    n_pend_data = val_rd;
                    n_nwr       = r_nwr + NW'(1);
                    n_cursor    = r_cursor + CW'(1);
                    if (n_nwr == NW'(MAX_WRITES_PER_TICK)) begin
                        n_state = trwr_pkg::ST_FLUSH;
                    end else if (32'(n_cursor) >= 32'(r_e_len)) begin
                        n_next   = r_next + EW'(1);
                        n_cursor = '0;
                        n_state  = (n_next >= r_count) ? trwr_pkg::ST_FLUSH
                                                       : trwr_pkg::ST_ENT;
                    end
                end
            end
            trwr_pkg::ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = trwr_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = trwr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = trwr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= trwr_pkg::MODE_IDLE;
            r_state   <= trwr_pkg::ST_IDLE;
            r_count   <= '0;
            r_fill    <= '0;
            r_next    <= '0;
            r_cursor  <= '0;
            r_elapsed <= '0;
            r_nwr     <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_state   <= n_state;
            r_count   <= n_count;
            r_fill    <= n_fill;
            r_next    <= n_next;
            r_cursor  <= n_cursor;
            r_elapsed <= n_elapsed;
            r_nwr     <= n_nwr;
            r_pend_v  <= n_pend_v;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last_time <= n_last_time;
        r_last_addr <= n_last_addr;
        r_last_off  <= n_last_off;
        r_last_len  <= n_last_len;
        r_e_addr    <= n_e_addr;
        r_e_off     <= n_e_off;
        r_e_len     <= n_e_len;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_last <= out_last;
            if (out_kind == trwr_pkg::KIND_REPORT) begin
                r_out_addr    <= '0;
                r_out_data    <= '0;
                r_out_state   <= n_mode;
                r_out_pos     <= 9'(n_next);
                r_out_total   <= 9'(n_count);
                r_out_elapsed <= (n_mode == trwr_pkg::MODE_PLAYING) ? n_elapsed : 32'd0;
                r_out_sts     <= out_sts;
            end else begin
                r_out_addr    <= out_addr;
                r_out_data    <= out_data;
                r_out_state   <= '0;
                r_out_pos     <= '0;
                r_out_total   <= '0;
                r_out_elapsed <= '0;
                r_out_sts     <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {2'b00, r_out_sts, r_out_elapsed, r_out_total, r_out_pos,
                         r_out_state, r_out_data, r_out_addr};

    // a held write only exists while a tick is being worked through
    `TRWR_ASSERT(a_pend_in_tick, i_clk, i_rst_n, r_pend_v |-> (r_state != trwr_pkg::ST_IDLE), "held write outside tick")
    // never more writes per tick than allowed
    `TRWR_ASSERT(a_nwr_limit, i_clk, i_rst_n, r_nwr <= NW'(MAX_WRITES_PER_TICK), "write budget exceeded")
    // playback position never runs past the table
    `TRWR_ASSERT(a_next_bound, i_clk, i_rst_n, r_next <= r_count, "position past entry count")
    // input is taken only by the idle sequencer
    `TRWR_ASSERT_NR(a_ready_idle, i_clk, o_s_tready |-> (r_state == trwr_pkg::ST_IDLE), "ready while busy")
endmodule
